@@ rtl/fmss_pkg.sv @@
// Package for the file magic and signature scanner.
// Holds the pattern table, type and finding codes, and the typing functions.
// No dependencies.
`default_nettype none

package fmss_pkg;

  localparam int unsigned HDR_DEPTH = 12;
  localparam int unsigned WIN_DEPTH = 13;
  localparam int unsigned PAT_MAX   = WIN_DEPTH + 1;
  localparam int unsigned NUM_PAT   = 12;
  localparam int unsigned NUM_FIND  = 9;
  localparam int unsigned CNT_W     = 22;

  localparam logic [CNT_W-1:0] SCAN_LIMIT = CNT_W'(2 * 1024 * 1024);
  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] SMALL_CERT = CNT_W'(256);

  typedef logic [7:0]                  byte_t;
  typedef logic [HDR_DEPTH-1:0][7:0]   hdr_t;
  typedef logic [WIN_DEPTH-1:0][7:0]   win_t;
  typedef logic [PAT_MAX-1:0][7:0]     seq_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [3:0]                  ftype_t;
  typedef logic [NUM_FIND-1:0]         find_t;
  typedef logic [1:0]                  level_t;
  typedef logic [3:0]                  plen_t;

  // pattern indexes
  localparam int unsigned P_JAVASCRIPT = 0;
  localparam int unsigned P_JS         = 1;
  localparam int unsigned P_OPENACTION = 2;
  localparam int unsigned P_LAUNCH     = 3;
  localparam int unsigned P_WORD       = 4;
  localparam int unsigned P_XL         = 5;
  localparam int unsigned P_VBA        = 6;
  localparam int unsigned P_DOTSLASH   = 7;
  localparam int unsigned P_DOTBSLASH  = 8;
  localparam int unsigned P_SYSTEM     = 9;
  localparam int unsigned P_BINSH      = 10;
  localparam int unsigned P_MZ         = 11;

  // right aligned: byte k is the k-th character from the end
  localparam logic [8*PAT_MAX-1:0] PAT_TEXT [NUM_PAT] = '{
    "/JavaScript", "/JS", "/OpenAction", "/Launch", "word/", "xl/",
    "vbaProject.bin", "../", "..\\", "system(", "/bin/sh", "MZ"
  };
  localparam plen_t PAT_LEN [NUM_PAT] = '{
    4'd11, 4'd3, 4'd11, 4'd7, 4'd5, 4'd3, 4'd14, 4'd3, 4'd3, 4'd7, 4'd7, 4'd2
  };

  // file types
  localparam ftype_t FT_UNKNOWN = 4'd0;
  localparam ftype_t FT_PDF     = 4'd1;
  localparam ftype_t FT_ELF     = 4'd2;
  localparam ftype_t FT_PNG     = 4'd3;
  localparam ftype_t FT_JPEG    = 4'd4;
  localparam ftype_t FT_ZIP     = 4'd5;
  localparam ftype_t FT_DOCX    = 4'd6;
  localparam ftype_t FT_XLSX    = 4'd7;
  localparam ftype_t FT_RAR     = 4'd8;
  localparam ftype_t FT_RPM     = 4'd9;
  localparam ftype_t FT_DEB     = 4'd10;
  localparam ftype_t FT_AVI     = 4'd11;
  localparam ftype_t FT_RIFF    = 4'd12;
  localparam ftype_t FT_MP4     = 4'd13;
  localparam ftype_t FT_MPEG    = 4'd14;
  localparam ftype_t FT_CERT    = 4'd15;

  // finding bits
  localparam int unsigned F_PDF_JS     = 0;
  localparam int unsigned F_OPEN_ACT   = 1;
  localparam int unsigned F_LAUNCH     = 2;
  localparam int unsigned F_MACRO      = 3;
  localparam int unsigned F_ZIP_TRAV   = 4;
  localparam int unsigned F_ELF_STR    = 5;
  localparam int unsigned F_IMG_EXE    = 6;
  localparam int unsigned F_SMALL_CERT = 7;
  localparam int unsigned F_PKG_TRAV   = 8;

  localparam level_t LVL_CLEAN      = 2'd0;
  localparam level_t LVL_SUSPICIOUS = 2'd1;
  localparam level_t LVL_DANGEROUS  = 2'd2;
  localparam level_t LVL_CRITICAL   = 2'd3;

  typedef struct packed {
    logic   pad;
    level_t threat_level;
    find_t  finding_bits;
    ftype_t file_type;
  } result_t;

  function automatic ftype_t magic_type(hdr_t h, cnt_t cnt);
    ftype_t t;
    t = FT_UNKNOWN;
    if (cnt < CNT_W'(4)) begin
      t = FT_UNKNOWN;
    end else if (h[0] == 8'h25 && h[1] == 8'h50 && h[2] == 8'h44 && h[3] == 8'h46) begin
      t = FT_PDF;
    end else if (h[0] == 8'h7F && h[1] == 8'h45 && h[2] == 8'h4C && h[3] == 8'h46) begin
      t = FT_ELF;
    end else if (h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4E && h[3] == 8'h47) begin
      t = FT_PNG;
    end else if (h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
      t = FT_JPEG;
    end else if (h[0] == 8'h50 && h[1] == 8'h4B && h[2] == 8'h03 && h[3] == 8'h04) begin
      t = FT_ZIP;
    end else if (h[0] == 8'h52 && h[1] == 8'h61 && h[2] == 8'h72 && h[3] == 8'h21) begin
      t = FT_RAR;
    end else if (h[0] == 8'hED && h[1] == 8'hAB && h[2] == 8'hEE && h[3] == 8'hDB) begin
      t = FT_RPM;
    end else if (cnt >= CNT_W'(7) && h[0] == 8'h21 && h[1] == 8'h3C && h[2] == 8'h61 &&
                 h[3] == 8'h72 && h[4] == 8'h63 && h[5] == 8'h68 && h[6] == 8'h3E) begin
      t = FT_DEB;
    end else if (h[0] == 8'h52 && h[1] == 8'h49 && h[2] == 8'h46 && h[3] == 8'h46) begin
      if (cnt >= CNT_W'(12) && h[8] == 8'h41 && h[9] == 8'h56 && h[10] == 8'h49 &&
          h[11] == 8'h20) begin
        t = FT_AVI;
      end else begin
        t = FT_RIFF;
      end
    end else if (cnt >= CNT_W'(8) && h[4] == 8'h66 && h[5] == 8'h74 && h[6] == 8'h79 &&
                 h[7] == 8'h70) begin
      t = FT_MP4;
    end else if (h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h01 &&
                 (h[3] == 8'hBA || h[3] == 8'hB3)) begin
      t = FT_MPEG;
    end else if (h[0] == 8'h30 && (h[1] == 8'h82 || h[1] == 8'h81)) begin
      t = FT_CERT;
    end
    return t;
  endfunction

  function automatic level_t threat(find_t f);
    level_t l;
    l = LVL_CLEAN;
    if (f[F_ELF_STR] || f[F_IMG_EXE] || f[F_SMALL_CERT]) l = LVL_SUSPICIOUS;
    if (f[F_PDF_JS] || f[F_OPEN_ACT] || f[F_ZIP_TRAV] || f[F_PKG_TRAV]) l = LVL_DANGEROUS;
    if (f[F_LAUNCH] || f[F_MACRO]) l = LVL_CRITICAL;
    return l;
  endfunction

endpackage

`default_nettype wire

@@ rtl/file_magic_and_signature_scanner.sv @@
// Channel  | Dir | tdata                         | tuser    | tlast
// s_axis   | in  | [7:0] data_byte               | has_byte | end_of_file
// m_axis   | out | [3:0] type [12:4] find [14:13]| -        | -
//
// One byte per cycle, sustained while no end-of-file transaction is stalled. A byte
// is registered on entry, matched from that register against the 12 patterns over
// the 14-byte window, and on end of file the result is registered in the output register.
// Only an end-of-file transaction waits on a full output register; bytes flow
// past a stalled result. rst (synchronous) clears counts, flags and valids.
// Depends on fmss_pkg.
`default_nettype none

module file_magic_and_signature_scanner
  import fmss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // has_byte
  input  wire logic        s_axis_tlast,   // end_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [3:0] file_type, [12:4] finding_bits,
                                           // [14:13] threat_level, [15] zero
);

  logic    in_valid;
  byte_t   in_byte;
  logic    in_has;
  logic    in_eof;

  hdr_t    header;
  win_t    window;
  cnt_t    byte_count;
  logic [NUM_PAT-1:0] seen;

  logic    out_valid;
  result_t out_data;

  logic    stall;
  logic    proc;
  logic    take;
  seq_t    seq;
  logic [NUM_PAT-1:0] hit;
  logic [NUM_PAT-1:0] seen_next;
  hdr_t    header_next;
  cnt_t    count_next;
  result_t result_next;

  assign stall         = in_valid && in_eof && out_valid && !m_axis_tready;
  assign s_axis_tready = !in_valid || !stall;
  assign proc          = in_valid && !stall;
  assign take          = proc && in_has;
  assign seq           = {window, in_byte};

  always_comb begin
    logic ok;
    for (int p = 0; p < NUM_PAT; p++) begin
      ok = (byte_count >= CNT_W'(PAT_LEN[p] - 4'd1)) && (byte_count < SCAN_LIMIT);
      for (int k = 0; k < PAT_MAX; k++) begin
        if (k < int'(PAT_LEN[p]) && seq[k] != PAT_TEXT[p][8*k +: 8]) ok = 1'b0;
      end
      hit[p] = ok;
    end
  end

  always_comb begin
    seen_next   = seen;
    header_next = header;
    count_next  = byte_count;
    if (in_has) begin
      seen_next = seen | hit;
      if (byte_count < CNT_W'(HDR_DEPTH)) header_next[byte_count[3:0]] = in_byte;
      if (byte_count != COUNT_MAX) count_next = byte_count + 1'b1;
    end
  end

  always_comb begin
    ftype_t t;
    find_t  f;
    logic   trav;
    t    = magic_type(header_next, count_next);
    f    = '0;
    trav = seen_next[P_DOTSLASH] || seen_next[P_DOTBSLASH];
    case (t) inside
      FT_PDF: begin
        f[F_PDF_JS]   = seen_next[P_JAVASCRIPT] || seen_next[P_JS];
        f[F_OPEN_ACT] = seen_next[P_OPENACTION];
        f[F_LAUNCH]   = seen_next[P_LAUNCH];
      end
      FT_ZIP: begin
        if (seen_next[P_WORD]) t = FT_DOCX;
        if (seen_next[P_XL]) t = FT_XLSX;
        f[F_MACRO]    = seen_next[P_VBA];
        f[F_ZIP_TRAV] = trav;
      end
      FT_ELF: f[F_ELF_STR] = seen_next[P_SYSTEM] || seen_next[P_BINSH];
      FT_PNG, FT_JPEG: f[F_IMG_EXE] = seen_next[P_MZ];
      FT_CERT: f[F_SMALL_CERT] = count_next < SMALL_CERT;
      FT_RPM, FT_DEB: f[F_PKG_TRAV] = trav;
      default: f = '0;
    endcase
    result_next.pad          = 1'b0;
    result_next.threat_level = threat(f);
    result_next.finding_bits = f;
    result_next.file_type    = t;
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_has  <= s_axis_tuser;
      in_eof  <= s_axis_tlast;
    end
    if (take) begin
      header <= header_next;
      window <= {window[WIN_DEPTH-2:0], in_byte};
    end
    if (proc && in_eof) begin
      out_data <= result_next;
    end
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      byte_count <= '0;
      seen       <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (m_axis_tready) out_valid <= 1'b0;
      if (proc) begin
        if (in_eof) begin
          out_valid  <= 1'b1;
          byte_count <= '0;
          seen       <= '0;
        end else begin
          byte_count <= count_next;
          seen       <= seen_next;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

@@ rtl/fmss_checker.sv @@
// Port-level checker for the file magic and signature scanner, with its bind.
// Depends on fmss_pkg and file_magic_and_signature_scanner.
`default_nettype none

module fmss_checker
  import fmss_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[12:4] == '0) == (m_axis_tdata[14:13] == LVL_CLEAN)))
    else $error("threat level disagrees with findings");

  a_pdf_gate: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[6:4] != '0) |-> m_axis_tdata[3:0] == FT_PDF)
    else $error("pdf finding on non-pdf type");

  a_zip_gate: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[8:7] != '0) |->
      (m_axis_tdata[3:0] == FT_ZIP || m_axis_tdata[3:0] == FT_DOCX ||
       m_axis_tdata[3:0] == FT_XLSX))
    else $error("archive finding on non-zip type");

endmodule

bind file_magic_and_signature_scanner fmss_checker u_fmss_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for file_magic_and_signature_scanner: streams whole files byte by byte,
// predicts type, findings and threat level per file, and checks each result in order.
// Depends on fmss_pkg and the scanner RTL.
`timescale 1ns / 1ps

module testbench;
  import fmss_pkg::*;

  localparam int SCAN_SPAN = 2097152;
  localparam int RANDOM_ITEMS = 1700;
  localparam int RANDOM_FILES_MIN = 30;

  typedef struct packed {
    level_t lvl;
    find_t  bits;
    ftype_t ftype;
  } verdict_t;

  class verdict_board;
    string    sig_text[12];
    byte_t    head[12];
    byte_t    recent[13];
    logic [11:0] hits;
    cnt_t     count;
    verdict_t pending[$];
    int       errors;
    int       verdicts_made;

    function new();
      sig_text = '{"/JavaScript", "/JS", "/OpenAction", "/Launch", "word/", "xl/",
                   "vbaProject.bin", "../", "..\\", "system(", "/bin/sh", "MZ"};
      errors = 0;
      verdicts_made = 0;
      clear();
    endfunction

    function void clear();
      foreach (head[i]) head[i] = '0;
      foreach (recent[i]) recent[i] = '0;
      hits = '0;
      count = '0;
    endfunction

    function void absorb(byte_t b);
      int n;
      logic hit;
      if (count < 12) head[count] = b;
      if (count < SCAN_SPAN) begin
        foreach (sig_text[p]) begin
          n = sig_text[p].len();
          hit = (count >= n - 1) && (b == byte_t'(sig_text[p][n-1]));
          for (int k = 1; hit && k < n; k++)
            hit = (recent[k-1] == byte_t'(sig_text[p][n-1-k]));
          if (hit) hits[p] = 1'b1;
        end
      end
      for (int k = 12; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (count != '1) count++;
    endfunction

    function ftype_t magic_of();
      if (count < 4) return FT_UNKNOWN;
      if ({head[0], head[1], head[2], head[3]} == 32'h25504446) return FT_PDF;
      if ({head[0], head[1], head[2], head[3]} == 32'h7F454C46) return FT_ELF;
      if ({head[0], head[1], head[2], head[3]} == 32'h89504E47) return FT_PNG;
      if ({head[0], head[1], head[2]} == 24'hFFD8FF) return FT_JPEG;
      if ({head[0], head[1], head[2], head[3]} == 32'h504B0304) return FT_ZIP;
      if ({head[0], head[1], head[2], head[3]} == 32'h52617221) return FT_RAR;
      if ({head[0], head[1], head[2], head[3]} == 32'hEDABEEDB) return FT_RPM;
      if (count >= 7 && {head[0], head[1], head[2], head[3], head[4], head[5], head[6]} ==
          56'h213C617263683E) return FT_DEB;
      if ({head[0], head[1], head[2], head[3]} == 32'h52494646) begin
        if (count >= 12 && {head[8], head[9], head[10], head[11]} == 32'h41564920)
          return FT_AVI;
        return FT_RIFF;
      end
      if (count >= 8 && {head[4], head[5], head[6], head[7]} == 32'h66747970) return FT_MP4;
      if ({head[0], head[1], head[2]} == 24'h000001 && (head[3] == 8'hBA || head[3] == 8'hB3))
        return FT_MPEG;
      if (head[0] == 8'h30 && (head[1] == 8'h82 || head[1] == 8'h81)) return FT_CERT;
      return FT_UNKNOWN;
    endfunction

    function level_t level_of(find_t f);
      level_t lv;
      level_t w;
      lv = LVL_CLEAN;
      for (int i = 0; i < NUM_FIND; i++) begin
        case (i)
          F_ELF_STR, F_IMG_EXE, F_SMALL_CERT: w = LVL_SUSPICIOUS;
          F_LAUNCH, F_MACRO:                  w = LVL_CRITICAL;
          default:                            w = LVL_DANGEROUS;
        endcase
        if (f[i] && w > lv) lv = w;
      end
      return lv;
    endfunction

    function void note_transaction(byte_t b, logic has_byte, logic eof);
      verdict_t v;
      logic trav;
      if (has_byte) absorb(b);
      if (!eof) return;
      v.ftype = magic_of();
      v.bits = '0;
      trav = hits[P_DOTSLASH] || hits[P_DOTBSLASH];
      case (v.ftype)
        FT_PDF: begin
          v.bits[F_PDF_JS] = hits[P_JAVASCRIPT] || hits[P_JS];
          v.bits[F_OPEN_ACT] = hits[P_OPENACTION];
          v.bits[F_LAUNCH] = hits[P_LAUNCH];
        end
        FT_ZIP: begin
          if (hits[P_WORD]) v.ftype = FT_DOCX;
          if (hits[P_XL]) v.ftype = FT_XLSX;
          v.bits[F_MACRO] = hits[P_VBA];
          v.bits[F_ZIP_TRAV] = trav;
        end
        FT_ELF: v.bits[F_ELF_STR] = hits[P_SYSTEM] || hits[P_BINSH];
        FT_PNG, FT_JPEG: v.bits[F_IMG_EXE] = hits[P_MZ];
        FT_CERT: v.bits[F_SMALL_CERT] = (count < 256);
        FT_RPM, FT_DEB: v.bits[F_PKG_TRAV] = trav;
        default: ;
      endcase
      v.lvl = level_of(v.bits);
      pending.insert(pending.size(), v);
      verdicts_made++;
      clear();
    endfunction

    function void check_result(logic [15:0] d);
      verdict_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with none expected, tdata %h", $time, d);
        return;
      end
      want = pending.pop_front();
      if (d[3:0] !== want.ftype || d[12:4] !== want.bits || d[14:13] !== want.lvl) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch type exp %0d got %0d, findings exp %b got %b, level exp %0d got %0d",
                   $time, want.ftype, d[3:0], want.bits, d[12:4], want.lvl, d[14:13]);
      end
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  verdict_board board;
  byte_t        file_q[$];
  logic         steady;
  int           sent_items;
  int           verdict_base;

  file_magic_and_signature_scanner DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap(logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) file_q.insert(file_q.size(), byte_t'(s[i]));
  endfunction

  function automatic void put_hex(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) file_q.insert(file_q.size(), v[8*i +: 8]);
  endfunction

  function automatic void put_noise(int n);
    for (int i = 0; i < n; i++) file_q.insert(file_q.size(), byte_t'($urandom_range(0, 255)));
  endfunction

  task automatic put_item(byte_t b, logic has_byte, logic eof);
    int gap;
    s_axis_tdata  <= b;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= eof;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_transaction(b, has_byte, eof);
    if (has_byte || eof) sent_items++;
    gap = pick_gap(steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // eof_on_byte = 0 closes the file with a separate empty transaction
  task automatic send_file(logic eof_on_byte);
    int n;
    n = file_q.size();
    if (n == 0) eof_on_byte = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) put_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      put_item(file_q[i], 1'b1, eof_on_byte && (i == n - 1));
    end
    if (!eof_on_byte) put_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);
    file_q.delete();
  endtask

  function automatic void build_random_file();
    int kind;
    int chunks;
    int p;
    int len;
    int cut;
    kind = $urandom_range(0, 14);
    case (kind)
      0:  put_text("%PDF-1.7");
      1:  put_hex(32'h7F454C46, 4);
      2:  put_hex(64'h89504E470D0A1A0A, 8);
      3:  put_hex(32'hFFD8FFE0, 4);
      4:  put_hex(32'h504B0304, 4);
      5:  put_text("Rar!");
      6:  put_hex(32'hEDABEEDB, 4);
      7:  put_text("!<arch>\n");
      8:  begin put_text("RIFF"); put_noise(4); put_text("WAVE"); end
      9:  begin put_text("RIFF"); put_noise(4); put_text("AVI "); end
      10: begin put_noise(4); put_text("ftypisom"); end
      11: put_hex(32'h000001BA, 4);
      12: put_hex(32'h000001B3, 4);
      13: put_hex($urandom_range(0, 1) ? 16'h3082 : 16'h3081, 2);
      default: put_noise($urandom_range(0, 12));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, file_q.size());
      while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
    end
    chunks = $urandom_range(0, 5);
    for (int c = 0; c < chunks; c++) begin
      if ($urandom_range(0, 1)) begin
        p = $urandom_range(0, 11);
        len = board.sig_text[p].len();
        put_text(board.sig_text[p]);
        case ($urandom_range(0, 7))
          0: file_q.delete(file_q.size() - 1);
          1: begin
            cut = file_q.size() - 1 - $urandom_range(0, len - 1);
            file_q[cut] = file_q[cut] ^ byte_t'($urandom_range(1, 255));
          end
          default: ;
        endcase
      end else begin
        put_noise($urandom_range(1, 8));
      end
    end
    if (kind == 13 && $urandom_range(0, 2) == 0) begin
      len = $urandom_range(250, 262);
      if (file_q.size() < len) put_noise(len - file_q.size());
    end
    if ($urandom_range(0, 24) == 0) put_noise($urandom_range(100, 400));
  endfunction

  initial begin
    int run;
    int hold;
    run = 0;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run > 0) begin
        run--;
        m_axis_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(20, 200);
        m_axis_tready <= 1'b1;
      end else begin
        hold = pick_gap(1'b0);
        m_axis_tready <= (hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  initial begin
    #250000000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    board = new();
    steady = 1'b0;
    sent_items = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_file(1'b0);
    put_text("%PD"); send_file(1'b1);
    put_text("%PDF"); send_file(1'b1);
    put_text("%PDF /JavaScript /OpenAction /Launch"); send_file(1'b0);
    put_text("%PDF /JS ../"); send_file(1'b1);
    put_hex(32'h7F454C46, 4); put_text("/bin/sh"); send_file(1'b1);
    put_hex(32'h7F454C46, 4); put_text("system("); send_file(1'b0);
    put_hex(32'h89504E47, 4); put_text("MZ"); send_file(1'b1);
    put_hex(24'hFFD8FF, 3); put_text("MZ"); send_file(1'b1);
    put_hex(32'h504B0304, 4); put_text("word/document.xml"); send_file(1'b1);
    put_hex(32'h504B0304, 4); put_text("xl/ word/"); send_file(1'b1);
    put_hex(32'h504B0304, 4); put_text("xl/vbaProject.bin ../a"); send_file(1'b1);
    put_hex(32'h504B0304, 4); put_text("..\\x"); send_file(1'b0);
    put_text("Rar!"); send_file(1'b1);
    put_hex(32'hEDABEEDB, 4); put_text("../"); send_file(1'b1);
    put_text("!<arch>..\\"); send_file(1'b1);
    put_text("!<arch"); send_file(1'b1);
    put_text("RIFF"); put_noise(4); put_text("AVI "); send_file(1'b1);
    put_text("RIFF"); put_noise(4); put_text("AVI"); send_file(1'b1);
    put_hex(64'h0, 4); put_text("ftyp"); send_file(1'b1);
    put_hex(64'h0, 4); put_text("fty"); send_file(1'b1);
    put_hex(32'h000001BA, 4); send_file(1'b1);
    put_hex(32'h000001B3, 4); send_file(1'b0);
    put_hex(16'h3082, 2); put_noise(253); send_file(1'b1);
    put_hex(16'h3081, 2); put_noise(254); send_file(1'b1);
    repeat (16) file_q.insert(file_q.size(), 8'hFF);
    send_file(1'b1);
    repeat (16) file_q.insert(file_q.size(), 8'h00);
    send_file(1'b1);

    verdict_base = board.verdicts_made;
    while (sent_items < RANDOM_ITEMS ||
           board.verdicts_made - verdict_base < RANDOM_FILES_MIN) begin
      steady = ($urandom_range(0, 4) == 0);
      build_random_file();
      send_file(logic'($urandom_range(0, 1)));
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fmss_pkg.sv
rtl/file_magic_and_signature_scanner.sv
rtl/fmss_checker.sv
dv/testbench.sv
